/* rtl/bfb_pkg.sv */
// ----------------------------------------------------------------------------
// bfb_pkg
// Shared sizes, codes, the reader cursor record and sequence helpers for the
// broadcast fan-out buffer.
// ----------------------------------------------------------------------------
`default_nettype none
package bfb_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int SA_W        = $clog2(STORE_BYTES);
  localparam int MAX_CHUNKS  = 256;
  localparam int CI_W        = $clog2(MAX_CHUNKS);
  localparam int MAX_CHUNK_BYTES = 2048;
  localparam int HALF_STORE  = STORE_BYTES / 2;
  localparam int CHUNK_CAP   = (MAX_CHUNK_BYTES < HALF_STORE) ? MAX_CHUNK_BYTES : HALF_STORE;
  localparam int NUM_READERS = 8;
  localparam int RID_W       = 3;
  localparam int MAX_RESULTS = 64;
  localparam int OB_W        = $clog2(MAX_RESULTS);
  localparam int CNT_W       = OB_W + 1;
  localparam int SEQ_W       = 48;
  localparam int LEN_W       = 12;
  localparam int HELD_W      = 13;
  localparam int LIVE_W      = 9;
  localparam int BUD_W       = 12;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_SUB   = 2'd2;
  localparam logic [1:0] OP_UNSUB = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSUB  = 2'd1;
  localparam logic [1:0] ST_NORDR  = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  typedef struct packed {
    logic             active;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] in_chunk;
    logic [SEQ_W-1:0] pos;
    logic [SEQ_W-1:0] dropped;
    logic [SEQ_W-1:0] delivered;
  } reader_t;

  typedef struct packed {
    logic    we;
    reader_t data;
  } rf_wr_t;

  // a strictly precedes b in modular order
  function automatic logic seq_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = b - a;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

  function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] d);
    logic [SEQ_W:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[SEQ_W] ? {SEQ_W{1'b1}} : s[SEQ_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/bfb_reader_file.sv */
// ----------------------------------------------------------------------------
// bfb_reader_file
// Cursor and counter record for every reader: one write port, one read port.
// ----------------------------------------------------------------------------
`default_nettype none
module bfb_reader_file import bfb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rf_wr_t           wr,
  input  wire logic [RID_W-1:0] widx,
  input  wire logic [RID_W-1:0] ridx,
  output reader_t               rdata,
  output logic                  any_active
);

  reader_t rf [NUM_READERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_READERS; i++) rf[i] <= '0;
    end else if (wr.we) begin
      rf[widx] <= wr.data;
    end
  end

  always_comb begin
    rdata      = rf[ridx];
    any_active = 1'b0;
    for (int i = 0; i < NUM_READERS; i++) any_active = any_active | rf[i].active;
  end

endmodule
`default_nettype wire

/* rtl/broadcast_fanout_buffer.sv */
// ----------------------------------------------------------------------------
// broadcast_fanout_buffer
// One-writer, eight-reader chunked broadcast buffer held in block memories.
// ----------------------------------------------------------------------------
// Commands are taken while busy is low and results come back on a one-cycle
// strobe that cannot be held off. A push that does not end a chunk goes
// straight to its result; ending a chunk commits it, first forcing the oldest
// chunk out when the chunk limit is reached, then drops the oldest chunks while
// over the byte budget and more than one is held. A read walks the stream one
// byte a cycle within a chunk from the byte memory, looks up the length of each
// chunk entered (again after a resync), runs the reader scan after each chunk
// finished and frees the chunks behind it, then sets up and plays the n bytes
// out on n strobes. Unsubscribe runs the same reader scan and frees chunks too.
// Every chunk length goes through the single read port of the length memory.
// ----------------------------------------------------------------------------
`default_nettype none
module broadcast_fanout_buffer import bfb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [2:0]  reader_id,
  input  wire logic [7:0]  push_byte,
  input  wire logic        chunk_end,
  input  wire logic [6:0]  read_max,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data,
  output logic             strobe,
  output logic [7:0]       data_byte,
  output logic             data_valid,
  output logic             last,
  output logic [1:0]       status,
  output logic [47:0]      dropped_total,
  output logic [47:0]      delivered_total,
  output logic [12:0]      stored_bytes,
  output logic [8:0]       stored_chunks
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DROP   = 4'd1;
  localparam logic [3:0] S_COMMIT = 4'd2;
  localparam logic [3:0] S_TRIM   = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_LEN    = 4'd5;
  localparam logic [3:0] S_BYTE   = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_FREE   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_OPRE   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_ONE    = 4'd12;

  logic [3:0]        state, ret, fret;
  logic [1:0]        op_q, stat;
  logic [RID_W-1:0]  rid, scan_i;
  logic [CNT_W-1:0]  cap, copied, k;
  logic [SEQ_W-1:0]  oldest_seq, head_seq, oldest_off, pushed, low;
  logic [LEN_W-1:0]  partial, len_cur;
  logic [HELD_W-1:0] held;
  logic [LIVE_W-1:0] live;
  logic [BUD_W-1:0]  budget;
  logic              pend, take;
  logic [OB_W-1:0]   pidx;

  logic [7:0]        byte_mem [STORE_BYTES];
  logic [LEN_W-1:0]  len_mem  [MAX_CHUNKS];
  logic [7:0]        obuf     [MAX_RESULTS];
  logic [7:0]        byte_q, obuf_q;
  logic [LEN_W-1:0]  len_q;
  logic [CI_W-1:0]   len_raddr;

  rf_wr_t            rf_wr;
  reader_t           rd;
  logic              any_active;
  logic [RID_W-1:0]  ridx, widx;

  logic [LEN_W-1:0]  plen;
  logic [BUD_W-1:0]  bud_now;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  // while idle the command's own reader is looked up straight from the port
  assign widx      = (state == S_IDLE) ? reader_id : rid;
  assign ridx      = (state == S_SCAN) ? scan_i : widx;
  assign len_raddr = (state == S_CHECK) ? rd.seq[CI_W-1:0] : oldest_seq[CI_W-1:0];
  assign plen      = partial + LEN_W'(1);
  assign take      = (state == S_BYTE) && (rd.in_chunk < len_cur) && (copied < cap);

  always_comb begin
    bud_now = (budget == '0) ? BUD_W'(1) : budget;
    if (bud_now > BUD_W'(HALF_STORE)) bud_now = BUD_W'(HALF_STORE);
  end

  bfb_reader_file u_rf (
    .clk        (clk),
    .rst        (rst),
    .wr         (rf_wr),
    .widx       (widx),
    .ridx       (ridx),
    .rdata      (rd),
    .any_active (any_active)
  );

  // memories
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && op == OP_PUSH && any_active)
      byte_mem[SA_W'(pushed[SA_W-1:0] + SA_W'(partial))] <= push_byte;
    byte_q <= byte_mem[rd.pos[SA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_COMMIT) len_mem[head_seq[CI_W-1:0]] <= partial;
    len_q <= len_mem[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (pend) obuf[pidx] <= byte_q;
    obuf_q <= obuf[k[OB_W-1:0]];
  end

  always_ff @(posedge clk) begin
    pend <= !rst && take;
  end

  // cursor write-back
  always_comb begin
    rf_wr.we   = 1'b0;
    rf_wr.data = rd;
    unique case (state)
      S_IDLE: begin
        if (start && op == OP_SUB && !rd.active) begin
          rf_wr.we   = 1'b1;
          rf_wr.data = '{active: 1'b1, seq: head_seq, in_chunk: '0, pos: pushed,
                         dropped: '0, delivered: '0};
        end else if (start && op == OP_UNSUB && rd.active) begin
          rf_wr.we          = 1'b1;
          rf_wr.data.active = 1'b0;
        end
      end
      S_CHECK: begin
        if (seq_before(rd.seq, oldest_seq)) begin
          rf_wr.we            = 1'b1;
          rf_wr.data.dropped  = sat_add(rd.dropped, oldest_off - rd.pos);
          rf_wr.data.seq      = oldest_seq;
          rf_wr.data.in_chunk = '0;
          rf_wr.data.pos      = oldest_off;
        end
      end
      S_BYTE: begin
        if (rd.in_chunk < len_cur && copied < cap) begin
          rf_wr.we            = 1'b1;
          rf_wr.data.in_chunk = rd.in_chunk + LEN_W'(1);
          rf_wr.data.pos      = rd.pos + SEQ_W'(1);
        end else if (rd.in_chunk >= len_cur) begin
          rf_wr.we            = 1'b1;
          rf_wr.data.seq      = rd.seq + SEQ_W'(1);
          rf_wr.data.in_chunk = '0;
        end
      end
      S_FIN: begin
        rf_wr.we             = 1'b1;
        rf_wr.data.delivered = sat_add(rd.delivered, SEQ_W'(copied));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      oldest_seq <= '0;
      head_seq   <= '0;
      oldest_off <= '0;
      pushed     <= '0;
      partial    <= '0;
      held       <= '0;
      live       <= '0;
      budget     <= BUD_W'(2048);
    end else begin
      if (cfg_valid && cfg_ready) budget <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q      <= op;
            rid       <= reader_id;
            cap       <= (read_max > 7'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : CNT_W'(read_max);
            copied    <= '0;
            stat      <= ST_OK;
            state     <= S_ONE;
            case (op)
              OP_PUSH: begin
                if (!any_active) begin
                  partial <= '0;
                  stat    <= ST_NORDR;
                end else begin
                  partial <= plen;
                  if (chunk_end || plen == LEN_W'(CHUNK_CAP)) begin
                    if (live >= LIVE_W'(MAX_CHUNKS)) begin
                      ret   <= S_COMMIT;
                      state <= S_DROP;
                    end else begin
                      state <= S_COMMIT;
                    end
                  end
                end
              end
              OP_READ: begin
                if (!rd.active) stat <= ST_NOSUB;
                else state <= S_CHECK;
              end
              OP_SUB: begin
                if (rd.active) stat <= ST_DUP;
              end
              default: begin
                if (!rd.active) begin
                  stat <= ST_NOSUB;
                end else begin
                  low    <= head_seq;
                  scan_i <= '0;
                  fret   <= S_ONE;
                  state  <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_DROP: begin
          oldest_off <= oldest_off + SEQ_W'(len_q);
          held       <= (HELD_W'(len_q) > held) ? '0 : held - HELD_W'(len_q);
          oldest_seq <= oldest_seq + SEQ_W'(1);
          live       <= live - LIVE_W'(1);
          state      <= ret;
        end
        S_COMMIT: begin
          pushed   <= pushed + SEQ_W'(partial);
          held     <= held + HELD_W'(partial);
          head_seq <= head_seq + SEQ_W'(1);
          live     <= live + LIVE_W'(1);
          partial  <= '0;
          state    <= S_TRIM;
        end
        S_TRIM: begin
          if (held > HELD_W'(bud_now) && live > LIVE_W'(1)) begin
            ret   <= S_TRIM;
            state <= S_DROP;
          end else begin
            state <= S_ONE;
          end
        end
        S_CHECK: begin
          // a resync rewrites the cursor, so look again next cycle
          if (!seq_before(rd.seq, oldest_seq)) begin
            if (!seq_before(rd.seq, head_seq)) state <= S_FIN;
            else state <= S_LEN;
          end
        end
        S_LEN: begin
          len_cur <= len_q;
          state   <= S_BYTE;
        end
        S_BYTE: begin
          if (rd.in_chunk < len_cur && copied < cap) begin
            pidx   <= copied[OB_W-1:0];
            copied <= copied + CNT_W'(1);
          end else if (rd.in_chunk >= len_cur) begin
            low    <= head_seq;
            scan_i <= '0;
            fret   <= (copied >= cap) ? S_FIN : S_CHECK;
            state  <= S_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_SCAN: begin
          if (rd.active && seq_before(rd.seq, low)) low <= rd.seq;
          scan_i <= scan_i + RID_W'(1);
          if (scan_i == RID_W'(NUM_READERS - 1)) state <= S_FREE;
        end
        S_FREE: begin
          if (live != '0 && seq_before(oldest_seq, low)) begin
            ret   <= S_FREE;
            state <= S_DROP;
          end else begin
            state <= fret;
          end
        end
        S_FIN: begin
          k     <= '0;
          state <= (copied == '0) ? S_ONE : S_OPRE;
        end
        S_OPRE: begin
          k     <= k + CNT_W'(1);
          state <= S_OUT;
        end
        S_OUT: begin
          k <= k + CNT_W'(1);
          if (k == copied) state <= S_IDLE;
        end
        S_ONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  logic show;
  assign show            = (op_q != OP_PUSH) && rd.active;
  assign strobe          = (state == S_OUT) || (state == S_ONE);
  assign data_valid      = (state == S_OUT);
  assign data_byte       = data_valid ? obuf_q : 8'd0;
  assign last            = (state == S_ONE) || (k == copied);
  assign status          = stat;
  assign dropped_total   = show ? rd.dropped : '0;
  assign delivered_total = show ? rd.delivered : '0;
  assign stored_bytes    = held;
  assign stored_chunks   = live;

  a_gap: assert property (@(posedge clk) disable iff (rst) strobe && last |=> !strobe)
    else $error("result strobe straight after last");
  a_live: assert property (@(posedge clk) disable iff (rst) live <= LIVE_W'(MAX_CHUNKS))
    else $error("chunk count beyond limit");
  a_single: assert property (@(posedge clk) disable iff (rst) strobe && !data_valid |-> last)
    else $error("empty result not last");
  a_okdata: assert property (@(posedge clk) disable iff (rst) data_valid |-> status == ST_OK)
    else $error("data with error status");

endmodule
`default_nettype wire

/* bench/tb_broadcast_fanout_buffer.sv */
// ----------------------------------------------------------------------------
// tb_broadcast_fanout_buffer
// Self-checking bench for the broadcast fan-out buffer. A scoreboard class
// keeps its own copy of the chunk rings and the reader cursors. It predicts
// every strobe of each accepted command and checks the strobes in order.
// Directed cases come first. Random traffic follows under several byte budgets
// and sender gap rates.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_broadcast_fanout_buffer;
  import bfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    bit [7:0]        data_byte;
    bit              data_valid;
    bit              last;
    bit [1:0]        status;
    bit [SEQ_W-1:0]  dropped;
    bit [SEQ_W-1:0]  delivered;
    bit [HELD_W-1:0] stored_bytes;
    bit [LIVE_W-1:0] stored_chunks;
  } bfb_result_t;

  class bfb_scoreboard;
    bit [7:0]        byte_mem [STORE_BYTES];
    int unsigned     chunk_len[MAX_CHUNKS];
    bit [SEQ_W-1:0]  oldest_seq, head_seq, oldest_off, pushed;
    int unsigned     partial, held, budget;
    bit              rd_active   [NUM_READERS];
    bit [SEQ_W-1:0]  rd_seq      [NUM_READERS];
    int unsigned     rd_in_chunk [NUM_READERS];
    bit [SEQ_W-1:0]  rd_pos      [NUM_READERS];
    bit [SEQ_W-1:0]  rd_dropped  [NUM_READERS];
    bit [SEQ_W-1:0]  rd_delivered[NUM_READERS];
    bfb_result_t     awaited[$];
    int              errors;

    function new();
      oldest_seq = '0; head_seq = '0; oldest_off = '0; pushed = '0;
      partial = 0; held = 0; budget = 2048; errors = 0;
      foreach (rd_active[i]) begin
        rd_active[i] = 0; rd_seq[i] = '0; rd_in_chunk[i] = 0;
        rd_pos[i] = '0; rd_dropped[i] = '0; rd_delivered[i] = '0;
      end
    endfunction

    function bit precedes(bit [SEQ_W-1:0] a, bit [SEQ_W-1:0] b);
      bit [SEQ_W-1:0] d;
      d = b - a;
      return (d != '0) && !d[SEQ_W-1];
    endfunction

    function bit [SEQ_W-1:0] sat48(bit [SEQ_W-1:0] a, bit [SEQ_W-1:0] d);
      bit [SEQ_W:0] s;
      s = {1'b0, a} + {1'b0, d};
      return s[SEQ_W] ? {SEQ_W{1'b1}} : s[SEQ_W-1:0];
    endfunction

    function int unsigned chunks_held();
      bit [SEQ_W-1:0] d;
      d = head_seq - oldest_seq;
      return int'(d);
    endfunction

    function int unsigned budget_limit();
      int unsigned b;
      b = (budget == 0) ? 1 : budget;
      return (b > HALF_STORE) ? HALF_STORE : b;
    endfunction

    function void set_budget(int unsigned v);
      budget = v & 12'hFFF;
    endfunction

    function void drop_oldest();
      int unsigned len;
      if (chunks_held() == 0) return;
      len = chunk_len[oldest_seq[CI_W-1:0]];
      oldest_off = oldest_off + len;
      held = (len > held) ? 0 : held - len;
      oldest_seq = oldest_seq + 1;
    endfunction

    function void free_behind();
      bit [SEQ_W-1:0] low;
      low = head_seq;
      for (int i = 0; i < NUM_READERS; i++)
        if (rd_active[i] && precedes(rd_seq[i], low)) low = rd_seq[i];
      while (chunks_held() > 0 && precedes(oldest_seq, low)) drop_oldest();
    endfunction

    function void append_byte(bit [7:0] b, bit ends);
      bit [SEQ_W-1:0] a;
      a = pushed + partial;
      byte_mem[a[SA_W-1:0]] = b;
      partial++;
      if (!ends && partial < CHUNK_CAP) return;
      if (chunks_held() >= MAX_CHUNKS) drop_oldest();
      chunk_len[head_seq[CI_W-1:0]] = partial;
      pushed = pushed + partial;
      held += partial;
      head_seq = head_seq + 1;
      partial = 0;
      while (held > budget_limit() && chunks_held() > 1) drop_oldest();
    endfunction

    function void fetch(int r, int unsigned cap, ref bit [7:0] got[$]);
      int unsigned len, avail, n, copied;
      bit [SEQ_W-1:0] a;
      copied = 0;
      forever begin
        if (precedes(rd_seq[r], oldest_seq)) begin
          rd_dropped[r]  = sat48(rd_dropped[r], oldest_off - rd_pos[r]);
          rd_seq[r]      = oldest_seq;
          rd_in_chunk[r] = 0;
          rd_pos[r]      = oldest_off;
        end
        if (!precedes(rd_seq[r], head_seq)) break;
        len   = chunk_len[rd_seq[r][CI_W-1:0]];
        avail = (rd_in_chunk[r] < len) ? len - rd_in_chunk[r] : 0;
        n     = (avail < cap - copied) ? avail : cap - copied;
        for (int k = 0; k < n; k++) begin
          a = rd_pos[r] + k;
          got.push_back(byte_mem[a[SA_W-1:0]]);
        end
        rd_in_chunk[r] += n;
        rd_pos[r] = rd_pos[r] + n;
        copied += n;
        if (rd_in_chunk[r] >= len) begin
          rd_seq[r] = rd_seq[r] + 1;
          rd_in_chunk[r] = 0;
          free_behind();
        end
        if (copied >= cap) break;
      end
      rd_delivered[r] = sat48(rd_delivered[r], copied);
    endfunction

    // predicts the strobes caused by one accepted command
    function void note_command(bit [1:0] op, bit [2:0] rid, bit [7:0] pb, bit ce,
                               bit [6:0] rmax);
      bit [7:0]    got[$];
      bit [1:0]    st;
      bit          any, show;
      int unsigned cap;
      int          cnt;
      bfb_result_t e;
      st  = ST_OK;
      cap = (rmax > MAX_RESULTS) ? MAX_RESULTS : rmax;
      case (op)
        OP_PUSH: begin
          any = 0;
          foreach (rd_active[i]) any |= rd_active[i];
          if (any) append_byte(pb, ce);
          else begin
            partial = 0;
            st = ST_NORDR;
          end
        end
        OP_READ: begin
          if (!rd_active[rid]) st = ST_NOSUB;
          else fetch(rid, cap, got);
        end
        OP_SUB: begin
          if (rd_active[rid]) st = ST_DUP;
          else begin
            rd_active[rid] = 1; rd_seq[rid] = head_seq; rd_in_chunk[rid] = 0;
            rd_pos[rid] = pushed; rd_dropped[rid] = '0; rd_delivered[rid] = '0;
          end
        end
        default: begin
          if (!rd_active[rid]) st = ST_NOSUB;
          else begin
            rd_active[rid] = 0;
            free_behind();
          end
        end
      endcase
      cnt  = (got.size() == 0) ? 1 : got.size();
      show = (op != OP_PUSH) && rd_active[rid];
      for (int k = 0; k < cnt; k++) begin
        e.data_valid    = (got.size() != 0);
        e.data_byte     = e.data_valid ? got[k] : 8'd0;
        e.last          = (k == cnt - 1);
        e.status        = st;
        e.dropped       = show ? rd_dropped[rid] : '0;
        e.delivered     = show ? rd_delivered[rid] : '0;
        e.stored_bytes  = held;
        e.stored_chunks = chunks_held();
        awaited.push_back(e);
      end
    endfunction

    function void check_result(bfb_result_t a);
      bfb_result_t e;
      if (awaited.size() == 0) begin
        $error("strobe with no result awaited");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (a.data_byte != e.data_byte) begin
        $error("data_byte: expected %0h, got %0h", e.data_byte, a.data_byte); errors++;
      end
      if (a.data_valid != e.data_valid) begin
        $error("data_valid: expected %0d, got %0d", e.data_valid, a.data_valid); errors++;
      end
      if (a.last != e.last) begin
        $error("last: expected %0d, got %0d", e.last, a.last); errors++;
      end
      if (a.status != e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status); errors++;
      end
      if (a.dropped != e.dropped) begin
        $error("dropped_total: expected %0d, got %0d", e.dropped, a.dropped); errors++;
      end
      if (a.delivered != e.delivered) begin
        $error("delivered_total: expected %0d, got %0d", e.delivered, a.delivered);
        errors++;
      end
      if (a.stored_bytes != e.stored_bytes) begin
        $error("stored_bytes: expected %0d, got %0d", e.stored_bytes, a.stored_bytes);
        errors++;
      end
      if (a.stored_chunks != e.stored_chunks) begin
        $error("stored_chunks: expected %0d, got %0d", e.stored_chunks, a.stored_chunks);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  op = OP_PUSH;
  logic [2:0]  reader_id = '0;
  logic [7:0]  push_byte = '0;
  logic        chunk_end = 0;
  logic [6:0]  read_max = '0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;
  logic        strobe;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        last;
  logic [1:0]  status;
  logic [47:0] dropped_total;
  logic [47:0] delivered_total;
  logic [12:0] stored_bytes;
  logic [8:0]  stored_chunks;

  bfb_scoreboard sb = new();
  int gap_pct = 0;
  int quiet_cycles = 0;

  broadcast_fanout_buffer u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .reader_id(reader_id), .push_byte(push_byte), .chunk_end(chunk_end),
    .read_max(read_max), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .strobe(strobe), .data_byte(data_byte),
    .data_valid(data_valid), .last(last), .status(status),
    .dropped_total(dropped_total), .delivered_total(delivered_total),
    .stored_bytes(stored_bytes), .stored_chunks(stored_chunks)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    bfb_result_t r;
    if (!rst && strobe) begin
      r.data_byte = data_byte; r.data_valid = data_valid; r.last = last;
      r.status = status; r.dropped = dropped_total; r.delivered = delivered_total;
      r.stored_bytes = stored_bytes; r.stored_chunks = stored_chunks;
      sb.check_result(r);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one command transfer; start stays high into the next command unless a gap falls
  task automatic issue(bit [1:0] o, bit [2:0] rid, bit [7:0] pb, bit ce, bit [6:0] rm);
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; op <= o; reader_id <= rid; push_byte <= pb; chunk_end <= ce;
    read_max <= rm;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(o, rid, pb, ce, rm);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.awaited.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_budget(bit [11:0] v);
    drain();
    cfg_valid <= 1; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_budget(v);
  endtask

  task automatic random_command();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      issue(OP_PUSH, 3'($urandom), 8'($urandom), $urandom_range(4) == 0, 7'($urandom));
    else if (pick < 80)
      issue(OP_READ, 3'($urandom), 8'($urandom), 1'($urandom), 7'($urandom_range(127)));
    else if (pick < 90)
      issue(OP_SUB, 3'($urandom), 8'($urandom), 1'($urandom), 7'($urandom));
    else
      issue(OP_UNSUB, 3'($urandom), 8'($urandom), 1'($urandom), 7'($urandom));
  endtask

  initial begin
    bit [11:0] budgets[6];
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_budget(12'd2048);

    // directed: push with nobody listening, then the basic flow
    issue(OP_PUSH, 0, 8'hFF, 0, 1);
    issue(OP_READ, 0, 0, 0, 1);
    issue(OP_UNSUB, 7, 0, 0, 1);
    issue(OP_SUB, 0, 0, 0, 1);
    issue(OP_SUB, 0, 0, 0, 1);
    issue(OP_SUB, 7, 0, 0, 1);
    issue(OP_PUSH, 0, 8'h00, 0, 0);
    issue(OP_PUSH, 0, 8'hA5, 1, 0);
    issue(OP_PUSH, 0, 8'h5A, 1, 0);
    issue(OP_READ, 0, 0, 0, 7'd0);
    issue(OP_READ, 0, 0, 0, 7'd127);
    issue(OP_READ, 7, 0, 0, 7'd64);
    issue(OP_READ, 7, 0, 0, 7'd64);
    issue(OP_UNSUB, 7, 0, 0, 1);
    // chunk overflow: 257 single-byte chunks while reader 0 holds them all
    for (int i = 0; i < MAX_CHUNKS + 1; i++) issue(OP_PUSH, 0, 8'(i), 1, 0);
    issue(OP_READ, 0, 0, 0, 7'd64);
    issue(OP_UNSUB, 0, 0, 0, 1);

    budgets = '{12'd1, 12'd4095, 12'd0, 12'd64, 12'($urandom_range(1, 300)), 12'd2048};
    for (int p = 0; p < 6; p++) begin
      write_budget(budgets[p]);
      gap_pct = (p < 2) ? 37 : (p < 4) ? 53 : 0;
      for (int i = 0; i < 26; i++) random_command();
    end

    drain();
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
rtl/bfb_pkg.sv
rtl/bfb_reader_file.sv
rtl/broadcast_fanout_buffer.sv
bench/tb_broadcast_fanout_buffer.sv
